// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands used by the RTL. They compile to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The consequent holds in the same cycle as the antecedent.
`define SMCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define SMCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SMCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SMCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/smcs_pkg.sv =====
// ----------------------------------------------------------------------------
// smcs_pkg
// Widths, register indexes and controller/datapath interface types of the
// slice macroblock command splitter.
// ----------------------------------------------------------------------------
package smcs_pkg;

    localparam int FIRST_W  = 12;   // first macroblock address
    localparam int COUNT_W  = 13;   // macroblock count
    localparam int ADDR_W   = 13;   // first address plus offset
    localparam int WIDTH_W  = 8;    // picture width, column, row, run
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 8;

    localparam int MAX_RESULTS = 33;
    localparam int NRES_W      = 6;
    localparam int DIV_CNT_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PIC_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XFORM     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY   = 2'd3;

    localparam logic [WIDTH_W-1:0] PIC_WIDTH_RESET = 8'd120;

    typedef struct packed {
        logic load;         // latch a new item and divide its first address
        logic take_addr;    // keep column/row, start dividing the chunk size
        logic take_chunk;   // keep chunk column step and row step
        logic emit;         // issue one command word
        logic emit_term;    // issue the terminator word
    } t_cmd;

    typedef struct packed {
        logic div_done;     // divider result valid this cycle
        logic count_zero;   // incoming slice has no macroblocks
        logic last_cmd;     // the command issued now ends the slice
    } t_status;

endpackage

// ===== rtl/core/smcs_divider.sv =====
// ----------------------------------------------------------------------------
// smcs_divider
// Restoring divider, one quotient bit per cycle. Divides a 13-bit dividend by
// an 8-bit nonzero divisor; the done pulse is raised with the last quotient bit.
// ----------------------------------------------------------------------------
module smcs_divider (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [smcs_pkg::ADDR_W-1:0]       i_dividend,
    input  logic [smcs_pkg::WIDTH_W-1:0]      i_divisor,
    output logic                              o_done,
    output logic [smcs_pkg::ADDR_W-1:0]       o_quotient,
    output logic [smcs_pkg::WIDTH_W-1:0]      o_remainder
);

    logic                              r_running;
    logic                              r_done;
    logic [smcs_pkg::DIV_CNT_W-1:0]    r_cnt;
    logic [smcs_pkg::ADDR_W-1:0]       r_quo;
    logic [smcs_pkg::WIDTH_W-1:0]      r_rem;
    logic [smcs_pkg::WIDTH_W-1:0]      r_divisor;

    logic [smcs_pkg::WIDTH_W:0]        trial;
    logic [smcs_pkg::WIDTH_W:0]        diff;
    logic                              ge;
    logic [smcs_pkg::WIDTH_W-1:0]      n_rem;

    always_comb begin
        trial = {r_rem, r_quo[smcs_pkg::ADDR_W-1]};
        ge    = trial >= {1'b0, r_divisor};
        diff  = trial - {1'b0, r_divisor};
        n_rem = ge ? diff[smcs_pkg::WIDTH_W-1:0] : trial[smcs_pkg::WIDTH_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_done    <= 1'b0;
            r_cnt     <= '0;
        end else if (i_start) begin
            r_running <= 1'b1;
            r_done    <= 1'b0;
            r_cnt     <= smcs_pkg::DIV_CNT_W'(smcs_pkg::ADDR_W);
        end else if (r_running) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == smcs_pkg::DIV_CNT_W'(1)) begin
                r_running <= 1'b0;
                r_done    <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo     <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_running) begin
            r_quo <= {r_quo[smcs_pkg::ADDR_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== rtl/core/smcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// smcs_ctrl
// Sequencer of the command splitter: a nonempty slice has two divisions, then
// one command word per cycle until covered; a frame end gives one terminator.
// ----------------------------------------------------------------------------
module smcs_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_func,
    input  smcs_pkg::t_status   i_status,
    output logic                o_busy,
    output smcs_pkg::t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV_A = 5'b00010,
        S_DIV_C = 5'b00100,
        S_EMIT  = 5'b01000,
        S_TERM  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_func) begin
                        n_state = S_TERM;
                    end else if (!i_status.count_zero) begin
                        n_state = S_DIV_A;
                    end
                end
            end
            S_DIV_A: begin
                if (i_status.div_done) begin
                    o_cmd.take_addr = 1'b1;
                    n_state = S_DIV_C;
                end
            end
            S_DIV_C: begin
                if (i_status.div_done) begin
                    o_cmd.take_chunk = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_status.last_cmd) begin
                    n_state = S_IDLE;
                end
            end
            S_TERM: begin
                o_cmd.emit_term = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/core/smcs_datapath.sv =====
// ----------------------------------------------------------------------------
// smcs_datapath
// Configuration registers, slice position tracking and the registered result
// word. Column and row of later commands are stepped from the divided first
// address and the divided chunk size.
// ----------------------------------------------------------------------------
module smcs_datapath #(
    parameter int MAX_MBS   = 4096,
    parameter int CHUNK_MBS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  smcs_pkg::t_cmd                      i_cmd,
    output smcs_pkg::t_status                   o_status,
    input  logic [smcs_pkg::FIRST_W-1:0]        i_slice_first_mb,
    input  logic [smcs_pkg::COUNT_W-1:0]        i_slice_mb_count,
    input  logic                                i_cfg_wr,
    input  logic [smcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smcs_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    output logic                                o_result_valid,
    output logic                                o_is_terminator,
    output logic [1:0]                          o_kernel_out,
    output logic [smcs_pkg::WIDTH_W-1:0]        o_start_col,
    output logic [smcs_pkg::WIDTH_W-1:0]        o_start_row,
    output logic [smcs_pkg::WIDTH_W-1:0]        o_row_width,
    output logic [smcs_pkg::WIDTH_W-1:0]        o_mb_run,
    output logic                                o_slice_start,
    output logic                                o_transform_flag,
    output logic [3:0]                          o_quality_out,
    output logic                                o_last
);

    localparam int W  = smcs_pkg::WIDTH_W;
    localparam int AW = smcs_pkg::ADDR_W;

    // Configuration.
    logic [W-1:0] r_pic_width;
    logic [1:0]   r_kernel;
    logic         r_xform;
    logic [3:0]   r_quality;

    // Slice progress.
    logic [AW-1:0]                  r_count;
    logic [AW-1:0]                  r_pos;
    logic [smcs_pkg::NRES_W-1:0]    r_nres;
    logic [W-1:0]                   r_col;
    logic [W-1:0]                   r_row;
    logic [W-1:0]                   r_col_step;
    logic [W-1:0]                   r_row_step;

    // Result word.
    logic         r_out_valid;
    logic         r_out_term;
    logic [1:0]   r_out_kernel;
    logic [W-1:0] r_out_col;
    logic [W-1:0] r_out_row;
    logic [W-1:0] r_out_width;
    logic [W-1:0] r_out_run;
    logic         r_out_first;
    logic         r_out_xform;
    logic [3:0]   r_out_quality;
    logic         r_out_last;

    logic [W-1:0]  w_eff;
    logic [AW-1:0] count_sat;
    logic          div_start;
    logic [AW-1:0] div_dividend;
    logic          div_done;
    logic [AW-1:0] div_quo;
    logic [W-1:0]  div_rem;

    logic          first_cmd;
    logic [AW:0]   pos_plus_chunk;
    logic [AW-1:0] run;
    logic [AW:0]   pos_next;
    logic          last_cmd;
    logic [W:0]    col_sum;
    logic          col_wrap;
    logic [W:0]    col_wrapped;

    // A width of zero is taken as one.
    assign w_eff = (r_pic_width == '0) ? W'(1) : r_pic_width;

    assign count_sat = (i_slice_mb_count > AW'(MAX_MBS)) ? AW'(MAX_MBS)
                                                         : AW'(i_slice_mb_count);

    assign div_start    = i_cmd.load || i_cmd.take_addr;
    assign div_dividend = i_cmd.load ? AW'(i_slice_first_mb) : AW'(CHUNK_MBS);

    smcs_divider u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (w_eff),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    always_comb begin
        first_cmd      = (r_pos == '0);
        pos_plus_chunk = {1'b0, r_pos} + (AW + 1)'(CHUNK_MBS);
        if (first_cmd) begin
            run = AW'(w_eff);
        end else if (pos_plus_chunk <= {1'b0, r_count}) begin
            run = AW'(CHUNK_MBS);
        end else begin
            run = r_count - r_pos;
        end
        pos_next = {1'b0, r_pos} + {1'b0, run};
        last_cmd = (pos_next >= {1'b0, r_count})
                || (r_nres == smcs_pkg::NRES_W'(smcs_pkg::MAX_RESULTS - 1));
        // Column plus the chunk step stays below twice the width.
        col_sum     = {1'b0, r_col} + {1'b0, r_col_step};
        col_wrap    = col_sum >= {1'b0, w_eff};
        col_wrapped = col_sum - {1'b0, w_eff};
    end

    assign o_status.div_done   = div_done;
    assign o_status.count_zero = (i_slice_mb_count == '0);
    assign o_status.last_cmd   = last_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pic_width <= smcs_pkg::PIC_WIDTH_RESET;
            r_kernel    <= '0;
            r_xform     <= 1'b0;
            r_quality   <= '0;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                smcs_pkg::CFG_PIC_WIDTH: r_pic_width <= i_cfg_data;
                smcs_pkg::CFG_KERNEL:    r_kernel    <= i_cfg_data[1:0];
                smcs_pkg::CFG_XFORM:     r_xform     <= i_cfg_data[0];
                smcs_pkg::CFG_QUALITY:   r_quality   <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_count <= count_sat;
            r_pos   <= '0;
            r_nres  <= '0;
        end
        if (i_cmd.take_addr) begin
            r_col <= div_rem;
            r_row <= div_quo[W-1:0];
        end
        if (i_cmd.take_chunk) begin
            r_col_step <= div_rem;
            r_row_step <= div_quo[W-1:0];
        end
        if (i_cmd.emit) begin
            r_pos  <= pos_next[AW-1:0];
            r_nres <= r_nres + 1'b1;
            if (first_cmd) begin
                // A full row keeps the column and moves one row down.
                r_row <= r_row + 1'b1;
            end else if (col_wrap) begin
                r_col <= col_wrapped[W-1:0];
                r_row <= r_row + r_row_step + 1'b1;
            end else begin
                r_col <= col_sum[W-1:0];
                r_row <= r_row + r_row_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.emit || i_cmd.emit_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_term) begin
            r_out_term    <= 1'b1;
            r_out_kernel  <= '0;
            r_out_col     <= '0;
            r_out_row     <= '0;
            r_out_width   <= '0;
            r_out_run     <= '0;
            r_out_first   <= 1'b0;
            r_out_xform   <= 1'b0;
            r_out_quality <= '0;
            r_out_last    <= 1'b1;
        end else if (i_cmd.emit) begin
            r_out_term    <= 1'b0;
            r_out_kernel  <= r_kernel;
            r_out_col     <= r_col;
            r_out_row     <= r_row;
            r_out_width   <= w_eff;
            r_out_run     <= run[W-1:0];
            r_out_first   <= first_cmd;
            r_out_xform   <= r_xform;
            r_out_quality <= r_quality;
            r_out_last    <= last_cmd;
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_is_terminator  = r_out_term;
    assign o_kernel_out     = r_out_kernel;
    assign o_start_col      = r_out_col;
    assign o_start_row      = r_out_row;
    assign o_row_width      = r_out_width;
    assign o_mb_run         = r_out_run;
    assign o_slice_start    = r_out_first;
    assign o_transform_flag = r_out_xform;
    assign o_quality_out    = r_out_quality;
    assign o_last           = r_out_last;

endmodule

// ===== rtl/core/slice_macroblock_command_splitter.sv =====
// ----------------------------------------------------------------------------
// slice_macroblock_command_splitter
// Splits slice items into macroblock work commands; frame-end items give a
// terminator word.
// ----------------------------------------------------------------------------
// One item is worked at a time: start is taken while busy is low. A slice
// item gives N commands (N at most 33): after the accept cycle the shared
// serial divider works bit by bit on the first address and then on the
// chunk size, after which one command word is issued per cycle. A frame-end
// item goes through the terminator state, and an empty slice never raises
// busy. Each word appears for exactly one cycle with o_result_valid high,
// in the cycle after it is issued; the receiver cannot hold words off and
// must take every one. Configuration writes are always taken and must only
// be issued while busy is low.
module slice_macroblock_command_splitter #(
    parameter int MAX_MBS   = 4096,
    parameter int CHUNK_MBS = 128
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_func,
    input  logic [smcs_pkg::FIRST_W-1:0]        i_slice_first_mb,
    input  logic [smcs_pkg::COUNT_W-1:0]        i_slice_mb_count,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [smcs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [smcs_pkg::CFG_DAT_W-1:0]      i_cfg_data,
    output logic                                o_result_valid,
    output logic                                o_is_terminator,
    output logic [1:0]                          o_kernel_out,
    output logic [smcs_pkg::WIDTH_W-1:0]        o_start_col,
    output logic [smcs_pkg::WIDTH_W-1:0]        o_start_row,
    output logic [smcs_pkg::WIDTH_W-1:0]        o_row_width,
    output logic [smcs_pkg::WIDTH_W-1:0]        o_mb_run,
    output logic                                o_slice_start,
    output logic                                o_transform_flag,
    output logic [3:0]                          o_quality_out,
    output logic                                o_last
);

`include "assert_macros.svh"

    smcs_pkg::t_cmd    cmd;
    smcs_pkg::t_status status;
    logic              accept;
    logic              cmd_out;
    logic              term_out;

    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;
    assign cmd_out     = o_result_valid && !o_is_terminator;
    assign term_out    = o_result_valid && o_is_terminator && o_last;

    smcs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (accept),
        .i_func   (i_func),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    smcs_datapath #(
        .MAX_MBS   (MAX_MBS),
        .CHUNK_MBS (CHUNK_MBS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_slice_first_mb (i_slice_first_mb),
        .i_slice_mb_count (i_slice_mb_count),
        .i_cfg_wr         (i_cfg_valid && o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_is_terminator  (o_is_terminator),
        .o_kernel_out     (o_kernel_out),
        .o_start_col      (o_start_col),
        .o_start_row      (o_start_row),
        .o_row_width      (o_row_width),
        .o_mb_run         (o_mb_run),
        .o_slice_start    (o_slice_start),
        .o_transform_flag (o_transform_flag),
        .o_quality_out    (o_quality_out),
        .o_last           (o_last)
    );

    // A terminator request shows up next cycle as a final terminator word.
    `SMCS_ASSERT_NXT(a_term_word, i_clk, i_rst_n, cmd.emit_term, term_out)
    // Stepped columns always stay inside the picture width.
    `SMCS_ASSERT_IMP(a_col_range, i_clk, i_rst_n, cmd_out, o_start_col < o_row_width)
    // Commands are only issued while an item is in progress.
    `SMCS_ASSERT_IMP(a_emit_busy, i_clk, i_rst_n, cmd.emit || cmd.emit_term, busy)

endmodule

// ===== verif/slice_macroblock_command_splitter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slice_macroblock_command_splitter_test
// Self-checking test of the slice command splitter. Slice and frame-end
// items go in through the start/busy port. A local model of the splitter
// turns each accepted item into the command words it should produce. Every
// strobed output word is compared field by field against the oldest
// outstanding word. Register writes happen only while the block is idle.
// ----------------------------------------------------------------------------
module slice_macroblock_command_splitter_test;

    localparam int unsigned MB_LIMIT  = 4096;
    localparam int unsigned MB_CHUNK  = 128;
    localparam int unsigned ITEMS_PER_PHASE = 75;
    localparam int unsigned NUM_PHASES      = 6;
    localparam int unsigned SETTLE_CYCLES   = 64;

    typedef struct packed {
        logic                           is_terminator;
        logic [1:0]                     kernel_out;
        logic [smcs_pkg::WIDTH_W-1:0]   start_col;
        logic [smcs_pkg::WIDTH_W-1:0]   start_row;
        logic [smcs_pkg::WIDTH_W-1:0]   row_width;
        logic [smcs_pkg::WIDTH_W-1:0]   mb_run;
        logic                           slice_start;
        logic                           transform_flag;
        logic [3:0]                     quality_out;
        logic                           last;
    } t_cmd_word;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               start;
    logic                               busy;
    logic                               i_func;
    logic [smcs_pkg::FIRST_W-1:0]       i_slice_first_mb;
    logic [smcs_pkg::COUNT_W-1:0]       i_slice_mb_count;
    logic                               i_cfg_valid;
    logic                               o_cfg_ready;
    logic [smcs_pkg::CFG_IDX_W-1:0]     i_cfg_index;
    logic [smcs_pkg::CFG_DAT_W-1:0]     i_cfg_data;
    logic                               o_result_valid;
    logic                               o_is_terminator;
    logic [1:0]                         o_kernel_out;
    logic [smcs_pkg::WIDTH_W-1:0]       o_start_col;
    logic [smcs_pkg::WIDTH_W-1:0]       o_start_row;
    logic [smcs_pkg::WIDTH_W-1:0]       o_row_width;
    logic [smcs_pkg::WIDTH_W-1:0]       o_mb_run;
    logic                               o_slice_start;
    logic                               o_transform_flag;
    logic [3:0]                         o_quality_out;
    logic                               o_last;

    // Shadow copy of the register file.
    logic [smcs_pkg::WIDTH_W-1:0]       pic_width_reg;
    logic [1:0]                         kernel_reg;
    logic                               xform_reg;
    logic [3:0]                         quality_reg;

    t_cmd_word              expected_words[$];
    int unsigned            mismatch_count;
    int unsigned            words_checked;
    int unsigned            slices_sent;
    int unsigned            frame_ends_sent;
    int unsigned            reg_writes;
    int unsigned            idle_pct;

    slice_macroblock_command_splitter dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_slice_first_mb (i_slice_first_mb),
        .i_slice_mb_count (i_slice_mb_count),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_result_valid   (o_result_valid),
        .o_is_terminator  (o_is_terminator),
        .o_kernel_out     (o_kernel_out),
        .o_start_col      (o_start_col),
        .o_start_row      (o_start_row),
        .o_row_width      (o_row_width),
        .o_mb_run         (o_mb_run),
        .o_slice_start    (o_slice_start),
        .o_transform_flag (o_transform_flag),
        .o_quality_out    (o_quality_out),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    // Works out the command words of one item and queues them.
    function automatic void split_slice(input logic func,
                                        input logic [smcs_pkg::FIRST_W-1:0] first,
                                        input logic [smcs_pkg::COUNT_W-1:0] count);
        t_cmd_word   w;
        int unsigned width;
        int unsigned total;
        int unsigned pos;
        int unsigned addr;
        int unsigned run;
        int unsigned n;
        w = '0;
        if (func) begin
            w.is_terminator = 1'b1;
            w.last = 1'b1;
            expected_words.push_back(w);
            return;
        end
        // A zero width behaves as a width of one.
        width = (pic_width_reg == 0) ? 1 : int'(pic_width_reg);
        total = (count > MB_LIMIT) ? MB_LIMIT : int'(count);
        pos = 0;
        n = 0;
        while (pos < total && n < smcs_pkg::MAX_RESULTS) begin
            addr = first + pos;
            if (pos == 0)
                run = width;
            else if (pos + MB_CHUNK <= total)
                run = MB_CHUNK;
            else
                run = total - pos;
            w.kernel_out     = kernel_reg;
            w.start_col      = smcs_pkg::WIDTH_W'(addr % width);
            w.start_row      = smcs_pkg::WIDTH_W'(addr / width);
            w.row_width      = smcs_pkg::WIDTH_W'(width);
            w.mb_run         = smcs_pkg::WIDTH_W'(run);
            w.slice_start    = (pos == 0);
            w.transform_flag = xform_reg;
            w.quality_out    = quality_reg;
            w.last           = 1'b0;
            expected_words.push_back(w);
            pos += run;
            n++;
        end
        if (n > 0)
            expected_words[expected_words.size() - 1].last = 1'b1;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Output words are sampled mid-cycle, where the strobe and fields are stable.
    always @(negedge i_clk) begin : word_check
        t_cmd_word want;
        if (i_rst_n && o_result_valid) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: no word outstanding");
                mismatch_count++;
            end else begin
                want = expected_words.pop_front();
                words_checked++;
                check_field("is_terminator", want.is_terminator, o_is_terminator);
                check_field("kernel_out", want.kernel_out, o_kernel_out);
                check_field("start_col", want.start_col, o_start_col);
                check_field("start_row", want.start_row, o_start_row);
                check_field("row_width", want.row_width, o_row_width);
                check_field("mb_run", want.mb_run, o_mb_run);
                check_field("slice_start", want.slice_start, o_slice_start);
                check_field("transform_flag", want.transform_flag, o_transform_flag);
                check_field("quality_out", want.quality_out, o_quality_out);
                check_field("last", want.last, o_last);
            end
        end
    end

    // Called at a rising edge; returns at the edge that took the item. Start
    // is left high so a following item can go out without a gap.
    task automatic send_item(input logic func, input logic [smcs_pkg::FIRST_W-1:0] first,
                             input logic [smcs_pkg::COUNT_W-1:0] count);
        logic taken;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_func           <= func;
        i_slice_first_mb <= first;
        i_slice_mb_count <= count;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        split_slice(func, first, count);
        if (func)
            frame_ends_sent++;
        else
            slices_sent++;
    endtask

    task automatic write_reg(input logic [smcs_pkg::CFG_IDX_W-1:0] index,
                             input logic [smcs_pkg::CFG_DAT_W-1:0] data);
        logic taken;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_cfg_ready;
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        case (index)
            smcs_pkg::CFG_PIC_WIDTH: pic_width_reg = data;
            smcs_pkg::CFG_KERNEL:    kernel_reg    = data[1:0];
            smcs_pkg::CFG_XFORM:     xform_reg     = data[0];
            smcs_pkg::CFG_QUALITY:   quality_reg   = data[3:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [smcs_pkg::CFG_DAT_W-1:0] width,
                                  input logic [smcs_pkg::CFG_DAT_W-1:0] kernel,
                                  input logic [smcs_pkg::CFG_DAT_W-1:0] xform,
                                  input logic [smcs_pkg::CFG_DAT_W-1:0] quality);
        write_reg(smcs_pkg::CFG_PIC_WIDTH, width);
        write_reg(smcs_pkg::CFG_KERNEL, kernel);
        write_reg(smcs_pkg::CFG_XFORM, xform);
        write_reg(smcs_pkg::CFG_QUALITY, quality);
    endtask

    // Waits for every outstanding word, then for busy to fall, then lets the
    // longest slice latency pass so an empty slice cannot still be in work.
    task automatic wait_drained();
        int unsigned cycles;
        start <= 1'b0;
        cycles = 0;
        while (expected_words.size() != 0 && cycles < 5000) begin
            @(posedge i_clk);
            cycles++;
        end
        if (expected_words.size() != 0) begin
            $error("%0d expected words never arrived", expected_words.size());
            mismatch_count++;
            expected_words.delete();
        end
        do
            @(negedge i_clk);
        while (busy);
        @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random_item();
        int unsigned pick;
        logic [smcs_pkg::FIRST_W-1:0] first;
        logic [smcs_pkg::COUNT_W-1:0] count;
        pick = $urandom_range(99);
        if (pick < 10)
            first = '0;
        else if (pick < 18)
            first = '1;
        else
            first = smcs_pkg::FIRST_W'($urandom_range(4095));
        pick = $urandom_range(99);
        if (pick < 6)
            count = '0;
        else if (pick < 46)
            count = smcs_pkg::COUNT_W'($urandom_range(1, 300));
        else if (pick < 74)
            count = smcs_pkg::COUNT_W'($urandom_range(1, 4096));
        else if (pick < 84)
            count = smcs_pkg::COUNT_W'($urandom_range(4097, 8191));
        else
            // Counts around the chunk boundaries and the saturation point.
            count = smcs_pkg::COUNT_W'($urandom_range(0, 32) * MB_CHUNK
                                       + $urandom_range(0, 2) - 1);
        if ($urandom_range(99) < 10)
            send_item(1'b1, smcs_pkg::FIRST_W'($urandom_range(4095)),
                      smcs_pkg::COUNT_W'($urandom_range(8191)));
        else
            send_item(1'b0, first, count);
    endtask

    task automatic test_reset_values();
        send_item(1'b0, 12'd0, 13'd240);
        send_item(1'b0, 12'd4095, 13'd1);
        send_item(1'b1, 12'd0, 13'd0);
        wait_drained();
    endtask

    task automatic test_width_one();
        write_all_regs(8'd1, 8'hFF, 8'hFF, 8'hFF);
        send_item(1'b0, 12'd4095, 13'd4096);
        send_item(1'b0, 12'd0, 13'd8191);
        send_item(1'b0, 12'd4095, 13'd0);
        send_item(1'b0, 12'd0, 13'd4097);
        send_item(1'b1, 12'd4095, 13'd8191);
        wait_drained();
    endtask

    task automatic test_width_extremes();
        write_all_regs(8'd255, 8'd2, 8'd0, 8'd0);
        // A short slice still claims a full picture width.
        send_item(1'b0, 12'd0, 13'd3);
        send_item(1'b0, 12'd4095, 13'd4096);
        send_item(1'b0, 12'd254, 13'd383);
        send_item(1'b0, 12'd0, 13'd256);
        wait_drained();
        write_all_regs(8'd0, 8'd1, 8'd1, 8'd7);
        send_item(1'b0, 12'd100, 13'd300);
        send_item(1'b0, 12'd4095, 13'd129);
        send_item(1'b0, 12'd0, 13'd0);
        send_item(1'b1, 12'd1, 13'd1);
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic [smcs_pkg::CFG_DAT_W-1:0] width;
        for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       width = 8'd1;
                1:       width = 8'd255;
                2:       width = 8'd0;
                default: width = smcs_pkg::CFG_DAT_W'($urandom_range(255));
            endcase
            write_all_regs(width, smcs_pkg::CFG_DAT_W'($urandom_range(255)),
                           smcs_pkg::CFG_DAT_W'($urandom_range(255)),
                           smcs_pkg::CFG_DAT_W'($urandom_range(255)));
            // One phase runs back to back with no sender gaps.
            idle_pct = (phase == 3) ? 0 : 34;
            for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++)
                send_random_item();
            wait_drained();
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        start            = 1'b0;
        i_func           = 1'b0;
        i_slice_first_mb = '0;
        i_slice_mb_count = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        pic_width_reg    = smcs_pkg::PIC_WIDTH_RESET;
        kernel_reg       = '0;
        xform_reg        = 1'b0;
        quality_reg      = '0;
        mismatch_count   = 0;
        words_checked    = 0;
        slices_sent      = 0;
        frame_ends_sent  = 0;
        reg_writes       = 0;
        idle_pct         = 34;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_width_one();
        test_width_extremes();
        test_random_phases();

        $display("Run covered %0d slices and %0d frame ends under %0d register writes.",
                 slices_sent, frame_ends_sent, reg_writes);
        $display("%0d command words were compared, %0d mismatches.",
                 words_checked, mismatch_count);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
